// ===== design/hcq_pkg.sv =====
// ----------------------------------------------------------------------------
// Hilbert curve key quantizer package
// Shared widths, register indexes, the curve state type and the per-level
// rotate and reflect step of the Hilbert mapping.
// ----------------------------------------------------------------------------
package hcq_pkg;

  localparam int unsigned LEVEL_BITS       = 21;
  localparam int unsigned TAG_BITS         = 16;
  localparam int unsigned KEY_BITS         = 2 * LEVEL_BITS;
  localparam int unsigned COORD_BITS       = 32;
  localparam int unsigned GAIN_BITS        = 32;
  localparam int unsigned PROD_BITS        = COORD_BITS + GAIN_BITS;
  localparam int unsigned LVL_IDX_BITS     = $clog2(LEVEL_BITS + 1);
  localparam int unsigned LEVELS_PER_STAGE = 7;
  localparam int unsigned CURVE_STAGES     =
      (LEVEL_BITS + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;

  localparam logic [LEVEL_BITS-1:0] CELL_MAX = '1;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_ORIGIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_GAIN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_GAIN   = 2'd3;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] x;
    logic [LEVEL_BITS-1:0] y;
    logic [KEY_BITS-1:0]   key;
  } hcq_curve_t;

  // One level of the curve: append the quadrant code, then rotate and
  // reflect the remaining lower bits when the point lies in a lower quadrant.
  function automatic hcq_curve_t curve_step(hcq_curve_t c, logic [LVL_IDX_BITS-1:0] lv);
    hcq_curve_t r;
    logic       rx;
    logic       ry;
    rx    = c.x[lv];
    ry    = c.y[lv];
    r     = c;
    r.key = {c.key[KEY_BITS-3:0], rx, rx ^ ry};
    if (!ry) begin
      if (rx) begin
        r.x = ~c.y;
        r.y = ~c.x;
      end else begin
        r.x = c.y;
        r.y = c.x;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/hilbert_curve_key_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// Hilbert curve key quantizer, top level
// Quantizes a Q16.16 point to a grid cell and returns its Hilbert curve key.
// ----------------------------------------------------------------------------
// The block takes one point in every clock cycle: busy is always low, so a
// transfer happens at every edge where start is high. Each point gives
// exactly one result, shown on curve_key_o and tag_out_o for one cycle while
// done_o is high, in input order. The receiver cannot stall the block, and it
// never needs to: results leave at the same rate as points arrive. The
// pipeline is a three-stage quantizer (origin subtract, 32 by 32 gain
// multiply, saturation to the grid) followed by a three-stage curve pipeline
// that resolves seven levels of the 21-level Hilbert curve per stage. Points
// below the origin land in cell zero, points beyond the grid land in the last
// cell, and a zero gain pins that axis to cell zero. The four configuration
// registers (x origin, y origin, x gain, y gain) are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; write them only while no point is in flight,
// since points already in the pipeline read them as they pass.
module hilbert_curve_key_quantizer_top import hcq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_wdata_i,
  input  logic [COORD_BITS-1:0]   x_coord_i,
  input  logic [COORD_BITS-1:0]   y_coord_i,
  input  logic [TAG_BITS-1:0]     point_tag_i,
  output logic [KEY_BITS-1:0]     curve_key_o,
  output logic [TAG_BITS-1:0]     tag_out_o
);

  logic [COORD_BITS-1:0] x_origin_q, y_origin_q;
  logic [GAIN_BITS-1:0]  x_gain_q, y_gain_q;

  logic                  accept;
  logic                  cell_valid;
  logic [LEVEL_BITS-1:0] x_cell, y_cell;
  logic [TAG_BITS-1:0]   cell_tag;

  // The pipeline never holds off its source.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      y_origin_q <= '0;
      x_gain_q   <= '0;
      y_gain_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_ORIGIN: x_origin_q <= cfg_wdata_i;
        REG_Y_ORIGIN: y_origin_q <= cfg_wdata_i;
        REG_X_GAIN:   x_gain_q   <= GAIN_BITS'(cfg_wdata_i);
        REG_Y_GAIN:   y_gain_q   <= GAIN_BITS'(cfg_wdata_i);
      endcase
    end
  end

  hcq_quant u_quant (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .tag_i      (point_tag_i),
    .x_origin_i (x_origin_q),
    .y_origin_i (y_origin_q),
    .x_gain_i   (x_gain_q),
    .y_gain_i   (y_gain_q),
    .valid_o    (cell_valid),
    .x_cell_o   (x_cell),
    .y_cell_o   (y_cell),
    .tag_o      (cell_tag)
  );

  hcq_curve u_curve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_valid),
    .x_cell_i (x_cell),
    .y_cell_i (y_cell),
    .tag_i    (cell_tag),
    .valid_o  (done_o),
    .key_o    (curve_key_o),
    .tag_o    (tag_out_o)
  );

endmodule

// ===== design/hcq_quant.sv =====
// ----------------------------------------------------------------------------
// Hilbert curve key quantizer: coordinate quantizer
// Three stages for both axes: origin subtract, gain multiply, saturate.
// ----------------------------------------------------------------------------
module hcq_quant import hcq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  input  logic [COORD_BITS-1:0] x_origin_i,
  input  logic [COORD_BITS-1:0] y_origin_i,
  input  logic [GAIN_BITS-1:0]  x_gain_i,
  input  logic [GAIN_BITS-1:0]  y_gain_i,
  output logic                  valid_o,
  output logic [LEVEL_BITS-1:0] x_cell_o,
  output logic [LEVEL_BITS-1:0] y_cell_o,
  output logic [TAG_BITS-1:0]   tag_o
);

  logic [1:0][COORD_BITS-1:0] coord;
  logic [1:0][COORD_BITS-1:0] origin;
  logic [1:0][GAIN_BITS-1:0]  gain;
  logic [1:0][COORD_BITS:0]   diff;
  logic [1:0][PROD_BITS-1:0]  prod;

  logic [1:0][COORD_BITS-1:0] mag_d, mag_q;
  logic [1:0][COORD_BITS-1:0] hi_d, hi_q;
  logic [1:0][LEVEL_BITS-1:0] cell_d, cell_q;
  logic [TAG_BITS-1:0]        tag_a_q, tag_b_q, tag_c_q;
  logic [2:0]                 vld_q;

  assign coord  = {y_coord_i, x_coord_i};
  assign origin = {y_origin_i, x_origin_i};
  assign gain   = {y_gain_i, x_gain_i};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // The exact difference fits 33 signed bits; a positive one fits 32 unsigned.
      diff[a]   = {coord[a][COORD_BITS-1], coord[a]} - {origin[a][COORD_BITS-1], origin[a]};
      mag_d[a]  = (!diff[a][COORD_BITS] && (|diff[a][COORD_BITS-1:0]))
                  ? diff[a][COORD_BITS-1:0] : '0;
      prod[a]   = PROD_BITS'(mag_q[a]) * PROD_BITS'(gain[a]);
      hi_d[a]   = prod[a][PROD_BITS-1:GAIN_BITS];
      cell_d[a] = (hi_q[a] > COORD_BITS'(CELL_MAX)) ? CELL_MAX : hi_q[a][LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mag_q   <= mag_d;
      tag_a_q <= tag_i;
    end
    if (vld_q[0]) begin
      hi_q    <= hi_d;
      tag_b_q <= tag_a_q;
    end
    if (vld_q[1]) begin
      cell_q  <= cell_d;
      tag_c_q <= tag_b_q;
    end
  end

  assign valid_o  = vld_q[2];
  assign x_cell_o = cell_q[0];
  assign y_cell_o = cell_q[1];
  assign tag_o    = tag_c_q;

endmodule

// ===== design/hcq_curve.sv =====
// ----------------------------------------------------------------------------
// Hilbert curve key quantizer: curve index pipeline
// Maps a cell to its Hilbert index, a fixed group of levels per stage.
// ----------------------------------------------------------------------------
module hcq_curve import hcq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [LEVEL_BITS-1:0] x_cell_i,
  input  logic [LEVEL_BITS-1:0] y_cell_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  output logic                  valid_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [TAG_BITS-1:0]   tag_o
);

  hcq_curve_t                          stage_in  [CURVE_STAGES];
  hcq_curve_t                          stage_out [CURVE_STAGES];
  hcq_curve_t                          cur_q     [CURVE_STAGES];
  logic [CURVE_STAGES-1:0][TAG_BITS-1:0] tag_q;
  logic [CURVE_STAGES-1:0]             vld_q;

  assign stage_in[0] = '{x: x_cell_i, y: y_cell_i, key: '0};

  for (genvar s = 1; s < CURVE_STAGES; s++) begin : g_link
    assign stage_in[s] = cur_q[s-1];
  end

  for (genvar s = 0; s < CURVE_STAGES; s++) begin : g_stage
    // Levels run from the most significant cell bit down.
    always_comb begin
      int lv;
      stage_out[s] = stage_in[s];
      for (int j = 0; j < LEVELS_PER_STAGE; j++) begin
        lv = int'(LEVEL_BITS) - 1 - (s * int'(LEVELS_PER_STAGE) + j);
        if (lv >= 0) begin
          stage_out[s] = curve_step(stage_out[s], LVL_IDX_BITS'(lv));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if ((s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s-1]) begin
        cur_q[s] <= stage_out[s];
        tag_q[s] <= (s == 0) ? tag_i : tag_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign valid_o = vld_q[CURVE_STAGES-1];
  assign key_o   = cur_q[CURVE_STAGES-1].key;
  assign tag_o   = tag_q[CURVE_STAGES-1];

endmodule
